[sv/sdse_pkg.sv]
// ----------------------------------------------------------------------------
// sdse_pkg: shared types and constants
// Payload structs, configuration struct, controller command/status and the
// saturation helper for the smoothed-derivative sensor expander.
// ----------------------------------------------------------------------------
`default_nettype none

package sdse_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_USE_IDENTITY = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_USE_FIRST    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_USE_SECOND   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SMOOTHING    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DERIV_SCALE  = 3'd4;

  localparam logic [15:0] SMOOTHING_RESET = 16'd6554;
  localparam logic [15:0] SCALE_RESET     = 16'd256;

  typedef struct packed {
    logic [5:0]         channel;
    logic signed [15:0] sample;
    logic signed [15:0] noise_value;
  } in_t;

  typedef struct packed {
    logic [5:0]         out_channel;
    logic signed [23:0] raw_out;
    logic signed [23:0] first_out;
    logic signed [23:0] second_out;
  } out_t;

  typedef struct packed {
    logic        use_identity;
    logic        use_first_derivative;
    logic        use_second_derivative;
    logic [15:0] smoothing_factor;
    logic [15:0] derivative_scale;
  } cfg_t;

  // operand pair for the shared multiplier
  typedef enum logic [1:0] {
    MUL_EPS = 2'd0,   // eps * (sample - s1)
    MUL_SQ  = 2'd1,   // scale * scale
    MUL_D1  = 2'd2,   // scale * (s0 - s1)
    MUL_D2  = 2'd3    // scale^2 * (s0 - 2*s1 + s2)
  } mul_sel_e;

  typedef struct packed {
    logic     clr;
    logic     load_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     load_s0;
    logic     load_sc2;
    logic     load_d1;
    logic     hist_we;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_status_t;

  function automatic logic signed [23:0] sat24(input logic signed [35:0] v);
    logic signed [23:0] r;
    if (v > 36'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -36'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/smoothed_derivative_sensor_expander.sv]
// ----------------------------------------------------------------------------
// smoothed_derivative_sensor_expander: top level
// Exponential smoothing per channel with scaled first and second differences,
// configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  input    | in_valid_i, in_stall_o, in_data_i     | in
//  output   | out_valid_o, out_stall_i, out_data_o  | out
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i       | in
//
//  With a derivative enabled, an item takes one accept step, four products
//  through the single shared multiplier and one output step.
//  With both derivatives off it goes from accept straight to the output step.
//  After reset, a clear sweep zeroes all CHANNELS history entries;
//  input stays stalled meanwhile, config writes are taken.
//  A stalled output beat holds the next item in its output step.
// ----------------------------------------------------------------------------
`default_nettype none

module smoothed_derivative_sensor_expander #(
  parameter int CHANNELS = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  sdse_pkg::in_t                         in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output sdse_pkg::out_t                        out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [sdse_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [sdse_pkg::CfgDataW-1:0]    cfg_data_i
);
  import sdse_pkg::*;

  cfg_t       cfg_q;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_identity          <= 1'b1;
      cfg_q.use_first_derivative  <= 1'b0;
      cfg_q.use_second_derivative <= 1'b0;
      cfg_q.smoothing_factor      <= SMOOTHING_RESET;
      cfg_q.derivative_scale      <= SCALE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_USE_IDENTITY: cfg_q.use_identity          <= cfg_data_i[0];
        CFG_USE_FIRST:    cfg_q.use_first_derivative  <= cfg_data_i[0];
        CFG_USE_SECOND:   cfg_q.use_second_derivative <= cfg_data_i[0];
        CFG_SMOOTHING:    cfg_q.smoothing_factor      <= cfg_data_i;
        CFG_DERIV_SCALE:  cfg_q.derivative_scale      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sdse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sdse_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

[sv/sdse_ctrl.sv]
// ----------------------------------------------------------------------------
// sdse_ctrl: sequencing state machine
// Runs the history clear sweep, takes one input beat at a time, runs the
// shared multiplier's four products with a derivative on, hands off to output.
// ----------------------------------------------------------------------------
`default_nettype none

module sdse_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  sdse_pkg::cfg_t             cfg_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  input  sdse_pkg::dp_status_t       status_i,
  output sdse_pkg::ctrl_cmd_t        cmd_o
);
  import sdse_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_EPS   = 7'b0000100,
    ST_SQ    = 7'b0001000,
    ST_D1    = 7'b0010000,
    ST_D2    = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;
  logic   deriv_on;

  assign deriv_on   = cfg_i.use_first_derivative | cfg_i.use_second_derivative;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_EPS;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load_in = 1'b1;
          state_d = deriv_on ? ST_EPS : ST_OUT;
        end
      end
      ST_EPS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_EPS;
        state_d = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SQ;
        cmd_o.load_s0 = 1'b1;
        state_d = ST_D1;
      end
      ST_D1: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_D1;
        cmd_o.load_sc2 = 1'b1;
        state_d = ST_D2;
      end
      ST_D2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_D2;
        cmd_o.load_d1 = 1'b1;
        cmd_o.hist_we = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // hold here until the output register can take the beat
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a pending beat");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input taken while an item is in flight");

  a_out_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("output valid raised outside output step");

endmodule

`default_nettype wire

[sv/sdse_dp.sv]
// ----------------------------------------------------------------------------
// sdse_dp: datapath
// Per-channel history memory, one shared signed multiplier, rounding and
// saturation, and the output payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdse_dp #(
  parameter int CHANNELS = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  sdse_pkg::cfg_t        cfg_i,
  input  sdse_pkg::in_t         in_data_i,
  input  sdse_pkg::ctrl_cmd_t   cmd_i,
  output sdse_pkg::dp_status_t  status_o,
  output sdse_pkg::out_t        out_data_o
);
  import sdse_pkg::*;

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [10:0] ChLim = 11'(CHANNELS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CHANNELS - 1);

  // entry: {latest s1, previous s2}
  logic [47:0] hist_mem [CHANNELS];

  logic [IdxW-1:0]     clr_cnt_q;
  logic [IdxW+5:0]     ch_ext;
  logic [IdxW-1:0]     rd_idx;
  logic [IdxW-1:0]     idx_q;
  logic                in_range_q;
  in_t                 in_q;
  logic [47:0]         rd_q;
  logic                wr_en;
  logic [IdxW-1:0]     wr_idx;
  logic [47:0]         wr_data;

  logic signed [23:0]  s1, s2;
  logic signed [23:0]  samp_q21;
  logic signed [24:0]  diff_e;
  logic signed [24:0]  d_e;
  logic signed [26:0]  dd;
  logic signed [32:0]  mul_a;
  logic signed [26:0]  mul_b;
  logic signed [59:0]  prod_q;
  logic signed [41:0]  s0_acc;
  logic signed [23:0]  s0_q;
  logic [31:0]         sc2_q;
  logic signed [41:0]  d1_acc;
  logic signed [24:0]  d1_q;
  logic signed [59:0]  d2_acc;
  logic signed [34:0]  d2r;
  logic                id, fd, sd;
  logic signed [35:0]  noise36, raw36, first36, second36;
  out_t                out_q, out_d;

  assign ch_ext = {{IdxW{1'b0}}, in_data_i.channel};
  assign rd_idx = ch_ext[IdxW-1:0];

  // clear sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end
  assign status_o.clr_last = (clr_cnt_q == LastIdx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q       <= in_data_i;
      idx_q      <= rd_idx;
      in_range_q <= ({5'd0, in_data_i.channel} < ChLim);
      rd_q       <= hist_mem[rd_idx];
    end
  end

  assign wr_en   = cmd_i.clr | (cmd_i.hist_we & in_range_q);
  assign wr_idx  = cmd_i.clr ? clr_cnt_q : idx_q;
  assign wr_data = cmd_i.clr ? 48'd0 : {s0_q, s1};

  always_ff @(posedge clk_i) begin
    if (wr_en) hist_mem[wr_idx] <= wr_data;
  end

  // out-of-range channels see an empty history
  assign s1 = in_range_q ? $signed(rd_q[47:24]) : 24'sd0;
  assign s2 = in_range_q ? $signed(rd_q[23:0])  : 24'sd0;

  assign samp_q21 = {in_q.sample, 8'd0};
  assign diff_e   = 25'(samp_q21) - 25'(s1);
  assign d_e      = 25'(s0_q) - 25'(s1);
  assign dd       = 27'(s0_q) - (27'(s1) <<< 1) + 27'(s2);

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_EPS: begin
        mul_a = $signed({17'd0, cfg_i.smoothing_factor});
        mul_b = 27'(diff_e);
      end
      MUL_SQ: begin
        mul_a = $signed({17'd0, cfg_i.derivative_scale});
        mul_b = $signed({11'd0, cfg_i.derivative_scale});
      end
      MUL_D1: begin
        mul_a = $signed({17'd0, cfg_i.derivative_scale});
        mul_b = 27'(d_e);
      end
      MUL_D2: begin
        mul_a = $signed({1'b0, sc2_q});
        mul_b = dd;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // s0 = s1 + eps*(sample - s1)/2^16, rounded half up
  assign s0_acc = (42'(s1) <<< 16) + 42'(prod_q) + 42'sd32768;
  assign d1_acc = 42'(prod_q) + 42'sd32768;
  assign d2_acc = prod_q + 60'sd8388608;
  assign d2r    = d2_acc[58:24];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en)   prod_q <= mul_a * mul_b;
    if (cmd_i.load_s0)  s0_q   <= sat24(36'($signed(s0_acc[41:16])));
    if (cmd_i.load_sc2) sc2_q  <= prod_q[31:0];
    if (cmd_i.load_d1)  d1_q   <= d1_acc[40:16];
  end

  assign fd = cfg_i.use_first_derivative;
  assign sd = cfg_i.use_second_derivative;
  assign id = cfg_i.use_identity | (~fd & ~sd);

  // noise goes to the first enabled field only
  assign noise36  = 36'(in_q.noise_value);
  assign raw36    = 36'(in_q.sample) + noise36;
  assign first36  = 36'(d1_q) + (id ? 36'sd0 : noise36);
  assign second36 = 36'(d2r) + ((id || fd) ? 36'sd0 : noise36);

  always_comb begin
    out_d.out_channel = in_q.channel;
    out_d.raw_out     = id ? sat24(raw36)    : 24'sd0;
    out_d.first_out   = fd ? sat24(first36)  : 24'sd0;
    out_d.second_out  = sd ? sat24(second36) : 24'sd0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire
